// ===== src/rps_pkg.sv =====
// Shared types and constants for the rotor positioner with stall guard.
package rps_pkg;

  typedef enum logic [1:0] {
    KIND_GO   = 2'd0,
    KIND_STOP = 2'd1,
    KIND_TICK = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    DRV_OFF = 2'd0,
    DRV_FWD = 2'd1,
    DRV_REV = 2'd2
  } drive_e;

  typedef enum logic [1:0] {
    REG_CHECK_INTERVAL = 2'd0,
    REG_APPROACH_STOP  = 2'd1,
    REG_MIN_MOVE_STEP  = 2'd2,
    REG_MIN_DELTA      = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [15:0] CheckIntervalRst = 16'd1000;
  localparam logic [14:0] ApproachStopRst  = 15'd2;
  localparam logic [15:0] MinMoveStepRst   = 16'd1;
  localparam logic [15:0] MinDeltaRst      = 16'd2;

  typedef struct packed {
    logic [15:0] check_interval_ms;
    logic [14:0] approach_stop;
    logic [15:0] min_move_step;
    logic [15:0] min_delta;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         direction;
    logic signed [15:0] goal;
    logic [15:0]        last_distance;
    logic [31:0]        now_ms;
    logic [31:0]        check_deadline;
  } state_t;

  typedef struct packed {
    logic [1:0] drive;
    logic       started;
    logic       ignored_close;
    logic       approach_stop_res;
    logic       wrong_direction;
    logic       stalled;
  } result_t;

endpackage

// ===== src/rps_cfg.sv =====
// Configuration register file of the rotor positioner.
module rps_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rps_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [rps_pkg::CfgDataWidth-1:0]    cfg_data_i,
  output rps_pkg::cfg_t                       cfg_o
);

  rps_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.check_interval_ms <= rps_pkg::CheckIntervalRst;
      cfg_q.approach_stop     <= rps_pkg::ApproachStopRst;
      cfg_q.min_move_step     <= rps_pkg::MinMoveStepRst;
      cfg_q.min_delta         <= rps_pkg::MinDeltaRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rps_pkg::REG_CHECK_INTERVAL: cfg_q.check_interval_ms <= cfg_data_i;
        rps_pkg::REG_APPROACH_STOP:  cfg_q.approach_stop     <= cfg_data_i[14:0];
        rps_pkg::REG_MIN_MOVE_STEP:  cfg_q.min_move_step     <= cfg_data_i;
        rps_pkg::REG_MIN_DELTA:      cfg_q.min_delta         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/rps_step.sv =====
// Next-state and result logic for one positioner request.
module rps_step (
  input  rps_pkg::cfg_t        cfg_i,
  input  rps_pkg::state_t      state_i,
  input  logic [1:0]           kind_i,
  input  logic signed [15:0]   target_i,
  input  logic signed [15:0]   position_i,
  output rps_pkg::state_t      state_o,
  output rps_pkg::result_t     result_o
);

  logic signed [16:0] pos_ext;
  logic signed [16:0] tgt_ext;
  logic signed [16:0] goal_ext;
  logic signed [16:0] go_diff;
  logic signed [16:0] go_neg;
  logic [15:0]        go_dist;
  logic signed [16:0] goal_diff;
  logic signed [16:0] goal_neg;
  logic [15:0]        cur_dist;
  logic signed [16:0] remain;
  logic               near;
  logic [16:0]        step_diff;
  logic [16:0]        step_neg;
  logic [15:0]        step_abs;
  logic [31:0]        now_inc;
  logic               due;

  assign pos_ext   = {position_i[15], position_i};
  assign tgt_ext   = {target_i[15], target_i};
  assign goal_ext  = {state_i.goal[15], state_i.goal};

  assign go_diff   = pos_ext - tgt_ext;
  assign go_neg    = -go_diff;
  assign go_dist   = go_diff[16] ? go_neg[15:0] : go_diff[15:0];

  assign goal_diff = pos_ext - goal_ext;
  assign goal_neg  = -goal_diff;
  assign cur_dist  = goal_diff[16] ? goal_neg[15:0] : goal_diff[15:0];
  assign remain    = (state_i.direction == rps_pkg::DRV_FWD) ? goal_neg : goal_diff;
  assign near      = remain < $signed({2'b00, cfg_i.approach_stop});

  assign step_diff = {1'b0, cur_dist} - {1'b0, state_i.last_distance};
  assign step_neg  = -step_diff;
  assign step_abs  = step_diff[16] ? step_neg[15:0] : step_diff[15:0];

  assign now_inc   = state_i.now_ms + 32'd1;
  assign due       = now_inc > state_i.check_deadline;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    case (kind_i)
      rps_pkg::KIND_GO: begin
        if (go_dist < cfg_i.min_delta) begin
          result_o.ignored_close = 1'b1;
        end else begin
          state_o.goal           = target_i;
          state_o.last_distance  = go_dist;
          state_o.check_deadline = state_i.now_ms + {16'd0, cfg_i.check_interval_ms};
          state_o.direction      = (target_i > position_i) ? rps_pkg::DRV_FWD
                                                           : rps_pkg::DRV_REV;
          result_o.started       = 1'b1;
        end
      end
      rps_pkg::KIND_STOP: begin
        state_o.direction = rps_pkg::DRV_OFF;
      end
      rps_pkg::KIND_TICK: begin
        state_o.now_ms = now_inc;
        if (state_i.direction != rps_pkg::DRV_OFF) begin
          if (near) begin
            state_o.direction          = rps_pkg::DRV_OFF;
            result_o.approach_stop_res = 1'b1;
          end
          if (due) begin
            state_o.check_deadline = now_inc + {16'd0, cfg_i.check_interval_ms};
            if (cur_dist > state_i.last_distance) begin
              state_o.direction        = rps_pkg::DRV_OFF;
              result_o.wrong_direction = 1'b1;
            end
            if (step_abs < cfg_i.min_move_step) begin
              state_o.direction = rps_pkg::DRV_OFF;
              result_o.stalled  = 1'b1;
            end
            state_o.last_distance = cur_dist;
          end
        end
      end
      default: ;
    endcase
    result_o.drive = state_o.direction;
  end

endmodule

// ===== src/rotor_positioner_stall_guard.sv =====
// Top level of the rotor positioner with stall guard.
//
// Input channel (in_valid_i/in_ready_o) carries one request per accepted edge:
// kind (go, stop, one-millisecond tick), target and measured position.
// Output channel (out_valid_o/out_ready_i) returns exactly one result per
// request, in order: drive after the request plus started, ignored_close,
// approach_stop_res, wrong_direction and stalled flags.
// Path: a request accepted into the request register is evaluated against the
// controller state and its result is loaded into the result register, where
// out_valid_o rises, once the output is not stalled.
// Throughput: one request per cycle unless stalled; the whole evaluation is a
// single pass of subtract/compare logic between request and result registers.
// Stall: while out_valid_o is high and out_ready_i low, the result holds, one
// more request waits in the request register, then in_ready_o drops.
// Reset: configuration returns to check interval 1000 ms, approach stop 2,
// min move step 1, min delta 2; drive off, goal, distance and counters zero.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must
// write it only while no request is in flight, which the block does not enforce.
module rotor_positioner_stall_guard (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       kind_i,
  input  logic signed [15:0]               target_i,
  input  logic signed [15:0]               position_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       drive_o,
  output logic                             started_o,
  output logic                             ignored_close_o,
  output logic                             approach_stop_res_o,
  output logic                             wrong_direction_o,
  output logic                             stalled_o,
  input  logic                             cfg_we_i,
  input  logic [rps_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [rps_pkg::CfgDataWidth-1:0] cfg_data_i
);

  rps_pkg::cfg_t      cfg;
  rps_pkg::state_t    state_q;
  rps_pkg::state_t    state_d;
  rps_pkg::result_t   result_d;
  rps_pkg::result_t   result_q;
  logic               req_valid_q;
  logic [1:0]         req_kind_q;
  logic signed [15:0] req_target_q;
  logic signed [15:0] req_position_q;
  logic               out_valid_q;
  logic               advance;
  logic               fire;

  rps_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rps_step u_step (
    .cfg_i      (cfg),
    .state_i    (state_q),
    .kind_i     (req_kind_q),
    .target_i   (req_target_q),
    .position_i (req_position_q),
    .state_o    (state_d),
    .result_o   (result_d)
  );

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = req_valid_q && advance;
  assign in_ready_o = !req_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_ready_o) begin
        req_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= req_valid_q;
      end
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_kind_q     <= kind_i;
      req_target_q   <= target_i;
      req_position_q <= position_i;
    end
    if (fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign drive_o             = result_q.drive;
  assign started_o           = result_q.started;
  assign ignored_close_o     = result_q.ignored_close;
  assign approach_stop_res_o = result_q.approach_stop_res;
  assign wrong_direction_o   = result_q.wrong_direction;
  assign stalled_o           = result_q.stalled;

`ifndef SYNTHESIS
  a_started_drives : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && started_o |-> drive_o != rps_pkg::DRV_OFF)
    else $error("started result without drive");

  a_stop_flags_off : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (approach_stop_res_o || wrong_direction_o || stalled_o)
      |-> drive_o == rps_pkg::DRV_OFF)
    else $error("stop flag with drive still on");

  a_tick_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && req_kind_q == rps_pkg::KIND_TICK
      |=> state_q.now_ms == $past(state_q.now_ms) + 32'd1)
    else $error("tick did not advance millisecond counter");

  a_drive_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> drive_o == state_q.direction)
    else $error("result drive differs from controller state");
`endif

endmodule
